>>> hdl/f2e_pkg.sv
// ----------------------------------------------------------------------------
// f2e_pkg
// Types, constants and tables shared by the float-to-text formatter.
// ----------------------------------------------------------------------------
package f2e_pkg;

	localparam int PREC_W          = 3;
	localparam logic [PREC_W-1:0] PREC_RESET = 3'd6;
	localparam logic [PREC_W-1:0] MAX_FRAC_DIGITS = 3'd7;
	localparam int POW_ENTRIES     = 77;

	localparam logic [30:0] MAG_INF = 31'h7f800000;

	localparam logic [6:0] CH_ZERO  = 7'h30;
	localparam logic [6:0] CH_POINT = 7'h2e;
	localparam logic [6:0] CH_MINUS = 7'h2d;
	localparam logic [6:0] CH_PLUS  = 7'h2b;
	localparam logic [6:0] CH_E     = 7'h65;
	localparam logic [6:0] CH_N     = 7'h6e;
	localparam logic [6:0] CH_A     = 7'h61;
	localparam logic [6:0] CH_I     = 7'h69;
	localparam logic [6:0] CH_F     = 7'h66;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LEAD,
		ST_WORD,
		ST_ZERO,
		ST_SEARCH,
		ST_MUL,
		ST_MULN,
		ST_DIV,
		ST_DIVN,
		ST_TAIL,
		ST_ROUND,
		ST_LIMIT,
		ST_DIGIT,
		ST_POINT,
		ST_EXP
	} f2e_state_t;

	typedef enum logic [1:0] {
		CL_NAN,
		CL_INF,
		CL_ZERO,
		CL_NORM
	} f2e_class_t;

	typedef logic [POW_ENTRIES-1:0][31:0] pow_tab_t;

	// Nearest single-precision value of ten to the power k, rounded to even.
	function automatic logic [31:0] f32_pow10(input int k);
		logic [191:0] q;
		logic [191:0] r;
		logic [191:0] den;
		logic [191:0] qq;
		logic [191:0] rem;
		logic [191:0] half;
		logic         sticky;
		int           s_exp;
		int           h;
		int           p;
		int           i;
		int           ebits;
		q      = 192'd1;
		r      = '0;
		den    = 192'd1;
		sticky = 1'b0;
		s_exp  = 0;
		if (k >= 0) begin
			for (i = 0; i < k; i++) begin
				q = q * 192'd10;
			end
		end else begin
			for (i = 0; i < -k; i++) begin
				den = den * 192'd10;
			end
			q = '0;
			for (i = 160; i >= 0; i--) begin
				r = {r[190:0], (i == 160)};
				q = {q[190:0], 1'b0};
				if (r >= den) begin
					r    = r - den;
					q[0] = 1'b1;
				end
			end
			sticky = (r != '0);
			s_exp  = 160;
		end
		h = 0;
		for (i = 0; i < 192; i++) begin
			if (q[i]) begin
				h = i;
			end
		end
		p = h - 23;
		if (p < s_exp - 149) begin
			p = s_exp - 149;
		end
		if (p <= 0) begin
			qq = q << (-p);
		end else begin
			qq   = q >> p;
			rem  = q & ((192'd1 << p) - 192'd1);
			half = 192'd1 << (p - 1);
			if ((rem > half) || ((rem == half) && (sticky || qq[0]))) begin
				qq = qq + 192'd1;
			end
		end
		ebits = p - s_exp + 150;
		return (32'(ebits) << 23) + qq[31:0] - 32'h00800000;
	endfunction

	function automatic pow_tab_t build_pow_tab();
		pow_tab_t t;
		int       j;
		for (j = 0; j < POW_ENTRIES; j++) begin
			t[j] = f32_pow10(j - 38);
		end
		return t;
	endfunction

	localparam pow_tab_t DEC_POW = build_pow_tab();

	function automatic logic [26:0] int_pow10(input logic [3:0] e);
		logic [26:0] v;
		case (e)
			4'd0: v = 27'd1;
			4'd1: v = 27'd10;
			4'd2: v = 27'd100;
			4'd3: v = 27'd1000;
			4'd4: v = 27'd10000;
			4'd5: v = 27'd100000;
			4'd6: v = 27'd1000000;
			4'd7: v = 27'd10000000;
			4'd8: v = 27'd100000000;
			default: v = 27'd0;
		endcase
		return v;
	endfunction

endpackage

>>> hdl/float32_to_e_format_text_top.sv
// Normal items pass through the six- or seven-step table search, then the mantissa multiply or
// the mantissa divider, then subtract steps for each decimal digit on the shared compare unit.
// Throughput: one item at a time; busy falls as the last character reaches the outputs.
// Characters leave at most one per cycle on strobe and cannot be stalled.
// Reset clears the sequencer and output strobe and sets precision to 6.
// ----------------------------------------------------------------------------
// float32_to_e_format_text_top
// Formats a single-precision bit pattern as scientific-notation ASCII text.
// ----------------------------------------------------------------------------
module float32_to_e_format_text_top (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [31:0]               value_bits,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [f2e_pkg::PREC_W-1:0] precision,
	output logic                      strobe,
	output logic [6:0]                text_char,
	output logic                      last_char
);
	import f2e_pkg::*;

	f2e_state_t        state_q;
	f2e_state_t        state_n;
	f2e_class_t        cls_q;
	logic [PREC_W-1:0] prec_q;
	logic [PREC_W-1:0] prec;
	logic [31:0]       bits_q;
	logic              neg_q;
	logic              sub_q;
	logic [3:0]        cnt_q;
	logic signed [7:0] lo_q;
	logic signed [7:0] hi_q;
	logic signed [6:0] expon_q;
	logic [47:0]       prod_q;
	logic [25:0]       divr_q;
	logic [26:0]       divq_q;
	logic [4:0]        step_q;
	logic [24:0]       mt_q;
	logic signed [9:0] et_q;
	logic [2:0]        tail_q;
	logic [48:0]       x_q;
	logic [27:0]       m_q;
	logic              ovf_q;
	logic [2:0]        dig_q;
	logic [3:0]        dval_q;
	logic              strobe_q;
	logic [6:0]        char_q;
	logic              last_q;

	logic              emit;
	logic [6:0]        emit_char;
	logic              emit_last;

	logic [30:0]       mag_in;
	logic [23:0]       mv;
	logic [7:0]        ev;
	logic signed [7:0] sum;
	logic signed [7:0] mid;
	logic signed [7:0] sc;
	logic              search_done;
	logic              search_ge;
	logic [6:0]        tab_idx;
	logic [31:0]       tab_val;
	logic [23:0]       mp;
	logic [7:0]        ep;
	logic              div_ge;
	logic [29:0]       trial;
	logic              dig_ge;
	logic [3:0]        dval_n;
	logic [5:0]        eabs;
	logic [1:0]        etens;
	logic [5:0]        eones;
	logic              lead_minus;
	logic [23:0]       nrm_keep;
	logic              nrm_g;
	logic              nrm_st;
	logic [9:0]        nrm_s;
	logic [63:0]       xw;
	logic [9:0]        et_neg;
	logic [5:0]        shamt;
	logic [27:0]       m_calc;

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign strobe    = strobe_q;
	assign text_char = char_q;
	assign last_char = last_q;

	assign prec   = (prec_q > MAX_FRAC_DIGITS) ? MAX_FRAC_DIGITS : prec_q;
	assign mag_in = value_bits[30:0];
	assign ev     = bits_q[30:23];
	assign mv     = {1'b1, bits_q[22:0]};

	assign sum         = lo_q + hi_q;
	assign mid         = $signed(sum + {7'd0, sum[7]}) >>> 1;
	assign search_done = (lo_q > hi_q);
	assign sc          = $signed({5'd0, prec}) - {expon_q[6], expon_q};

	always_comb begin
		tab_idx = 7'd38;
		case (state_q)
			ST_SEARCH: tab_idx = 7'(mid + 8'sd38);
			ST_MUL:    tab_idx = (sc > 8'sd38) ? 7'd76 : 7'(sc + 8'sd38);
			ST_MULN:   tab_idx = (sc > 8'sd38) ? 7'd76 : 7'(sc + 8'sd38);
			ST_DIV:    tab_idx = 7'(8'sd38 - sc);
			ST_DIVN:   tab_idx = 7'(8'sd38 - sc);
			default:   tab_idx = 7'd38;
		endcase
	end

	assign tab_val   = DEC_POW[tab_idx];
	assign ep        = tab_val[30:23];
	assign mp        = {1'b1, tab_val[22:0]};
	assign search_ge = ({1'b0, bits_q[30:0]} >= tab_val);
	assign div_ge    = (divr_q >= {2'b0, mp});

	assign trial  = {int_pow10({1'b0, dig_q} + {3'd0, ovf_q}), 3'd0} >> step_q[1:0];
	assign dig_ge = ({2'b0, m_q} >= trial);
	assign dval_n = dval_q | (dig_ge ? (4'd8 >> step_q[1:0]) : 4'd0);

	assign eabs  = expon_q[6] ? 6'(-expon_q) : 6'(expon_q);
	assign etens = (eabs >= 6'd30) ? 2'd3 : (eabs >= 6'd20) ? 2'd2 :
		(eabs >= 6'd10) ? 2'd1 : 2'd0;
	assign eones = eabs - 6'(etens * 4'd10);

	assign lead_minus = neg_q && ((cls_q == CL_INF) || (cls_q == CL_NORM) ||
		((cls_q == CL_ZERO) && sub_q));

	always_comb begin
		nrm_keep = '0;
		nrm_g    = 1'b0;
		nrm_st   = 1'b0;
		nrm_s    = '0;
		if (state_q == ST_MULN) begin
			if (prod_q[47]) begin
				nrm_keep = prod_q[47:24];
				nrm_g    = prod_q[23];
				nrm_st   = |prod_q[22:0];
				nrm_s    = 10'd24;
			end else begin
				nrm_keep = prod_q[46:23];
				nrm_g    = prod_q[22];
				nrm_st   = |prod_q[21:0];
				nrm_s    = 10'd23;
			end
		end else begin
			if (divq_q[26]) begin
				nrm_keep = divq_q[26:3];
				nrm_g    = divq_q[2];
				nrm_st   = (|divq_q[1:0]) || (divr_q != '0);
				nrm_s    = 10'd3;
			end else begin
				nrm_keep = divq_q[25:2];
				nrm_g    = divq_q[1];
				nrm_st   = divq_q[0] || (divr_q != '0);
				nrm_s    = 10'd2;
			end
		end
	end

	assign xw     = {15'd0, x_q};
	assign et_neg = 10'(-et_q);

	always_comb begin
		if (!et_q[9]) begin
			shamt  = (et_q > 10'sd63) ? 6'd63 : et_q[5:0];
			m_calc = 28'(xw << shamt);
		end else begin
			shamt  = (et_neg > 10'd63) ? 6'd63 : et_neg[5:0];
			m_calc = 28'((xw >> shamt) + {63'd0, xw[shamt - 6'd1]});
		end
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE:   state_n = start ? ST_LEAD : ST_IDLE;
			ST_LEAD: begin
				case (cls_q)
					CL_ZERO: state_n = ST_ZERO;
					CL_NORM: state_n = ST_SEARCH;
					default: state_n = ST_WORD;
				endcase
			end
			ST_WORD:   state_n = (cnt_q == 4'd2) ? ST_IDLE : ST_WORD;
			ST_ZERO:   state_n = (cnt_q == 4'({1'b0, prec} + 4'd1)) ? ST_EXP : ST_ZERO;
			ST_SEARCH: begin
				if (search_done) begin
					state_n = sc[7] ? ST_DIV : ST_MUL;
				end
			end
			ST_MUL:    state_n = ST_MULN;
			ST_MULN:   state_n = ST_TAIL;
			ST_DIV:    state_n = (step_q == 5'd26) ? ST_DIVN : ST_DIV;
			ST_DIVN:   state_n = ST_TAIL;
			ST_TAIL:   state_n = ST_ROUND;
			ST_ROUND:  state_n = ST_LIMIT;
			ST_LIMIT:  state_n = ST_DIGIT;
			ST_DIGIT: begin
				if (step_q[1:0] == 2'd3) begin
					if (dig_q == prec) begin
						state_n = ST_POINT;
					end else if (dig_q == 3'd0) begin
						state_n = ST_EXP;
					end
				end
			end
			ST_POINT:  state_n = (dig_q == 3'd0) ? ST_EXP : ST_DIGIT;
			ST_EXP:    state_n = (cnt_q == 4'd3) ? ST_IDLE : ST_EXP;
			default:   state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		emit      = 1'b0;
		emit_char = CH_ZERO;
		emit_last = 1'b0;
		case (state_q)
			ST_LEAD: begin
				emit      = lead_minus;
				emit_char = CH_MINUS;
			end
			ST_WORD: begin
				emit      = 1'b1;
				emit_last = (cnt_q == 4'd2);
				if (cls_q == CL_NAN) begin
					emit_char = (cnt_q == 4'd1) ? CH_A : CH_N;
				end else begin
					case (cnt_q)
						4'd0:    emit_char = CH_I;
						4'd1:    emit_char = CH_N;
						default: emit_char = CH_F;
					endcase
				end
			end
			ST_ZERO: begin
				emit      = 1'b1;
				emit_char = (cnt_q == 4'd1) ? CH_POINT : CH_ZERO;
			end
			ST_DIGIT: begin
				emit      = (step_q[1:0] == 2'd3);
				emit_char = CH_ZERO + 7'((dval_n > 4'd9) ? 4'd9 : dval_n);
			end
			ST_POINT: begin
				emit      = 1'b1;
				emit_char = CH_POINT;
			end
			ST_EXP: begin
				emit      = 1'b1;
				emit_last = (cnt_q == 4'd3);
				case (cnt_q)
					4'd0:    emit_char = CH_E;
					4'd1:    emit_char = expon_q[6] ? CH_MINUS : CH_PLUS;
					4'd2:    emit_char = CH_ZERO + 7'(etens);
					default: emit_char = CH_ZERO + 7'(eones);
				endcase
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			prec_q   <= PREC_RESET;
			cnt_q    <= '0;
			step_q   <= '0;
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
		end else begin
			state_q  <= state_n;
			strobe_q <= emit;
			last_q   <= emit && emit_last;
			if (cfg_valid) begin
				prec_q <= precision;
			end
			if (state_n != state_q) begin
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_q + 4'd1;
			end
			case (state_q)
				ST_DIV:   step_q <= step_q + 5'd1;
				ST_DIGIT: step_q <= (step_q[1:0] == 2'd3) ? 5'd0 : step_q + 5'd1;
				default:  step_q <= '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		char_q <= emit_char;
		case (state_q)
			ST_IDLE: begin
				bits_q  <= value_bits;
				neg_q   <= value_bits[31];
				sub_q   <= (mag_in != '0);
				lo_q    <= -8'sd38;
				hi_q    <= 8'sd38;
				expon_q <= (mag_in > MAG_INF || mag_in == MAG_INF ||
					value_bits[30:23] == 8'd0) ? 7'sd0 : -7'sd38;
				if (mag_in > MAG_INF) begin
					cls_q <= CL_NAN;
				end else if (mag_in == MAG_INF) begin
					cls_q <= CL_INF;
				end else if (value_bits[30:23] == 8'd0) begin
					cls_q <= CL_ZERO;
				end else begin
					cls_q <= CL_NORM;
				end
			end
			ST_SEARCH: begin
				if (!search_done) begin
					if (search_ge) begin
						expon_q <= mid[6:0];
						lo_q    <= mid + 8'sd1;
					end else begin
						hi_q <= mid - 8'sd1;
					end
				end else begin
					divr_q <= {2'b0, mv};
					divq_q <= '0;
					tail_q <= '0;
				end
			end
			ST_MUL: begin
				prod_q <= mv * mp;
				tail_q <= (sc > 8'sd38) ? 3'(sc - 8'sd38) : 3'd0;
			end
			ST_DIV: begin
				divq_q <= {divq_q[25:0], div_ge};
				divr_q <= 26'((div_ge ? (divr_q - {2'b0, mp}) : divr_q) << 1);
			end
			ST_MULN: begin
				mt_q <= {1'b0, nrm_keep} + {24'd0, nrm_g & (nrm_st | nrm_keep[0])};
				et_q <= $signed({2'b0, ev}) + $signed({2'b0, ep}) - 10'sd300 +
					$signed(nrm_s);
			end
			ST_DIVN: begin
				mt_q <= {1'b0, nrm_keep} + {24'd0, nrm_g & (nrm_st | nrm_keep[0])};
				et_q <= $signed({2'b0, ev}) - $signed({2'b0, ep}) - 10'sd26 +
					$signed(nrm_s);
			end
			ST_TAIL: begin
				x_q <= 49'(mt_q * int_pow10({1'b0, tail_q}));
			end
			ST_ROUND: begin
				m_q <= m_calc;
			end
			ST_LIMIT: begin
				ovf_q  <= ({1'b0, m_q} >= {2'b0, int_pow10(4'({1'b0, prec} + 4'd1))});
				if ({1'b0, m_q} >= {2'b0, int_pow10(4'({1'b0, prec} + 4'd1))}) begin
					expon_q <= expon_q + 7'sd1;
				end
				dig_q  <= prec;
				dval_q <= '0;
			end
			ST_DIGIT: begin
				if (dig_ge) begin
					m_q <= m_q - trial[27:0];
				end
				if (step_q[1:0] == 2'd3) begin
					dval_q <= '0;
					if (dig_q != prec && dig_q != 3'd0) begin
						dig_q <= dig_q - 3'd1;
					end
				end else begin
					dval_q <= dval_n;
				end
			end
			ST_POINT: begin
				if (dig_q != 3'd0) begin
					dig_q <= dig_q - 3'd1;
				end
			end
			default: begin
				dval_q <= dval_q;
			end
		endcase
	end

endmodule
